/* design/ute_pkg.sv */
// ute_pkg: shared types, constants and helper functions of the utf8 token estimator
// used by every module of the block; depends on nothing else
package ute_pkg;

    // counter and output widths
    localparam int COUNT_BITS = 24;
    localparam int OUT_BITS   = 24;
    localparam int EST_BITS   = COUNT_BITS + 2;
    localparam int WIN_DEPTH  = 3;
    localparam int WIN_CNT_BITS = 2;
    localparam int INC_BITS   = 3;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [OUT_BITS-1:0]   OUT_MAX   = '1;

    // utf-8 byte patterns
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;
    localparam logic [7:0] ASCII_LIMIT = 8'h80;

    // ascii character classes
    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_0     = 8'h30;
    localparam logic [7:0] ASCII_9     = 8'h39;
    localparam logic [7:0] ASCII_UP_A  = 8'h41;
    localparam logic [7:0] ASCII_UP_Z  = 8'h5A;
    localparam logic [7:0] ASCII_LO_A  = 8'h61;
    localparam logic [7:0] ASCII_LO_Z  = 8'h7A;

    // cjk ideograph range
    localparam logic [15:0] CJK_LO = 16'h4E00;
    localparam logic [15:0] CJK_HI = 16'h9FA5;

    // alnum weight 2/5, tracked as running quotient and remainder
    localparam logic [2:0] ALNUM_NUM = 3'd2;
    localparam logic [2:0] ALNUM_DEN = 3'd5;

    // input word
    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [OUT_BITS-1:0] token_estimate;
        logic [OUT_BITS-1:0] cjk_total;
        logic [OUT_BITS-1:0] alnum_total;
        logic [OUT_BITS-1:0] space_total;
        logic [OUT_BITS-1:0] symbol_total;
    } t_out_word;

    // pending bytes of an undecided sequence
    typedef struct packed {
        logic [WIN_CNT_BITS-1:0]     count;
        logic [WIN_DEPTH-1:0][7:0]   bytes;
    } t_window;

    // per-byte counter increments from the decoder
    typedef struct packed {
        logic                cjk;
        logic                alnum;
        logic                space;
        logic [INC_BITS-1:0] symbol;
    } t_incr;

    // final totals of one text
    typedef struct packed {
        logic [COUNT_BITS-1:0] cjk;
        logic [COUNT_BITS-1:0] alnum;
        logic [COUNT_BITS-1:0] alnum_q;
        logic [COUNT_BITS-1:0] space;
        logic [COUNT_BITS-1:0] symbol;
    } t_totals;

    // continuation byte test
    function automatic logic f_is_cont(input logic [7:0] b);
        return (b & CONT_MASK) == CONT_CODE;
    endfunction

    // continuation bytes needed after a lead, zero when not a lead
    function automatic logic [WIN_CNT_BITS-1:0] f_cont_needed(input logic [7:0] b);
        logic [WIN_CNT_BITS-1:0] n;
        n = '0;
        if ((b & LEAD3_MASK) == LEAD3_CODE) begin
            n = 2'd2;
        end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
            n = 2'd1;
        end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
            n = 2'd3;
        end
        return n;
    endfunction

    // saturating counter add
    function automatic logic [COUNT_BITS-1:0] f_sat_inc(
        input logic [COUNT_BITS-1:0] c,
        input logic [INC_BITS-1:0]   inc
    );
        logic [COUNT_BITS:0] s;
        s = {1'b0, c} + {(COUNT_BITS - INC_BITS + 1)'(0), inc};
        return s[COUNT_BITS] ? COUNT_MAX : s[COUNT_BITS-1:0];
    endfunction

    // clamp to the output field width
    function automatic logic [OUT_BITS-1:0] f_sat_out(input logic [EST_BITS-1:0] v);
        logic [OUT_BITS-1:0] r;
        if (v > EST_BITS'(OUT_MAX)) begin
            r = OUT_MAX;
        end else begin
            r = OUT_BITS'(v);
        end
        return r;
    endfunction

endpackage

/* design/ute_decode.sv */
// ute_decode: pending byte window and per-byte unit classification
// uses ute_pkg types and helper functions
module ute_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  ute_pkg::t_in_word i_word,
    output ute_pkg::t_incr    o_incr
);

    ute_pkg::t_window r_win;
    ute_pkg::t_window n_win;
    ute_pkg::t_incr   n_incr;

    // decide units from the pending prefix plus the new byte
    always_comb begin
        logic [ute_pkg::WIN_CNT_BITS-1:0] p;
        logic [ute_pkg::WIN_CNT_BITS-1:0] need;
        logic [7:0]                       b;
        logic [15:0]                      cp;
        logic                             rescan;
        p      = r_win.count;
        need   = ute_pkg::f_cont_needed(r_win.bytes[0]);
        b      = i_word.text_byte;
        cp     = {r_win.bytes[0][3:0], r_win.bytes[1][5:0], b[5:0]};
        rescan = 1'b0;
        n_incr = '0;
        n_win  = '0;
        if (p == '0) begin
            rescan = 1'b1;
        end else if (ute_pkg::f_is_cont(b)) begin
            if (p == need) begin
                // sequence complete
                if (need == 2'd2 && cp >= ute_pkg::CJK_LO && cp <= ute_pkg::CJK_HI) begin
                    n_incr.cjk = 1'b1;
                end else begin
                    n_incr.symbol = 3'd1;
                end
            end else if (i_word.last_byte) begin
                // truncated at end: lead and every continuation are symbols
                n_incr.symbol = {1'b0, p} + 3'd1;
            end else begin
                // extend the pending prefix
                n_win.count = p + 2'd1;
                for (int i = 0; i < ute_pkg::WIN_DEPTH; i++) begin
                    if (2'(i) < p) begin
                        n_win.bytes[i] = r_win.bytes[i];
                    end else if (2'(i) == p) begin
                        n_win.bytes[i] = b;
                    end
                end
            end
        end else begin
            // broken sequence: lead and its continuations are symbols
            n_incr.symbol = {1'b0, p};
            rescan        = 1'b1;
        end
        // the new byte starts a unit of its own
        if (rescan) begin
            if (b < ute_pkg::ASCII_LIMIT) begin
                if ((b >= ute_pkg::ASCII_UP_A && b <= ute_pkg::ASCII_UP_Z) ||
                    (b >= ute_pkg::ASCII_LO_A && b <= ute_pkg::ASCII_LO_Z) ||
                    (b >= ute_pkg::ASCII_0 && b <= ute_pkg::ASCII_9)) begin
                    n_incr.alnum = 1'b1;
                end else if (b == ute_pkg::ASCII_SPACE) begin
                    n_incr.space = 1'b1;
                end else begin
                    n_incr.symbol = n_incr.symbol + 3'd1;
                end
            end else if (ute_pkg::f_cont_needed(b) == '0 || i_word.last_byte) begin
                n_incr.symbol = n_incr.symbol + 3'd1;
            end else begin
                n_win.count    = 2'd1;
                n_win.bytes[0] = b;
            end
        end
    end

    // window register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (i_take) begin
            r_win <= n_win;
        end
    end

    assign o_incr = n_incr;

endmodule

/* design/ute_tally.sv */
// ute_tally: saturating unit counters and the captured totals of a finished text
// uses ute_pkg types and ute_pkg::f_sat_inc
module ute_tally (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic             i_last,
    input  ute_pkg::t_incr   i_incr,
    input  logic             i_fin_take,
    output logic             o_fin_vld,
    output ute_pkg::t_totals o_fin
);

    ute_pkg::t_totals r_cnt;
    ute_pkg::t_totals n_cnt;
    logic [2:0]       r_alr;
    logic [2:0]       n_alr;
    ute_pkg::t_totals r_fin;
    logic             r_fin_vld;

    // next counter values, alnum tracked with running floor(2a/5)
    always_comb begin
        logic       al_inc;
        logic [2:0] rem;
        al_inc         = i_incr.alnum && (r_cnt.alnum != ute_pkg::COUNT_MAX);
        rem            = r_alr + ute_pkg::ALNUM_NUM;
        n_cnt.cjk      = ute_pkg::f_sat_inc(r_cnt.cjk, {2'b00, i_incr.cjk});
        n_cnt.space    = ute_pkg::f_sat_inc(r_cnt.space, {2'b00, i_incr.space});
        n_cnt.symbol   = ute_pkg::f_sat_inc(r_cnt.symbol, i_incr.symbol);
        n_cnt.alnum    = ute_pkg::f_sat_inc(r_cnt.alnum, {2'b00, al_inc});
        n_cnt.alnum_q  = r_cnt.alnum_q;
        n_alr          = r_alr;
        if (al_inc) begin
            if (rem >= ute_pkg::ALNUM_DEN) begin
                n_alr         = rem - ute_pkg::ALNUM_DEN;
                n_cnt.alnum_q = r_cnt.alnum_q + ute_pkg::COUNT_BITS'(1);
            end else begin
                n_alr = rem;
            end
        end
    end

    // counters clear after the last byte of a text
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_alr <= '0;
        end else if (i_take) begin
            if (i_last) begin
                r_cnt <= '0;
                r_alr <= '0;
            end else begin
                r_cnt <= n_cnt;
                r_alr <= n_alr;
            end
        end
    end

    // totals holding stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_vld <= 1'b0;
        end else if (i_take && i_last) begin
            r_fin_vld <= 1'b1;
        end else if (i_fin_take) begin
            r_fin_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && i_last) begin
            r_fin <= n_cnt;
        end
    end

    assign o_fin_vld = r_fin_vld;
    assign o_fin     = r_fin;

endmodule

/* design/ute_result.sv */
// ute_result: token estimate sum with saturation, and the output word register
// uses ute_pkg types and ute_pkg::f_sat_out
module ute_result (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fin_vld,
    input  ute_pkg::t_totals   i_fin,
    input  logic               i_stall,
    output logic               o_fin_take,
    output logic               o_valid,
    output ute_pkg::t_out_word o_word
);

    logic               r_valid;
    ute_pkg::t_out_word r_word;
    ute_pkg::t_out_word n_word;
    logic               fin_take;

    assign fin_take = i_fin_vld && (!r_valid || !i_stall);

    // floor(cjk/2) + floor(2*alnum/5) + symbols, clamped
    always_comb begin
        logic [ute_pkg::EST_BITS-1:0] est;
        est = ute_pkg::EST_BITS'(i_fin.cjk >> 1) + ute_pkg::EST_BITS'(i_fin.alnum_q) +
              ute_pkg::EST_BITS'(i_fin.symbol);
        if (est > ute_pkg::EST_BITS'(ute_pkg::COUNT_MAX)) begin
            est = ute_pkg::EST_BITS'(ute_pkg::COUNT_MAX);
        end
        n_word.token_estimate = ute_pkg::f_sat_out(est);
        n_word.cjk_total      = ute_pkg::f_sat_out(ute_pkg::EST_BITS'(i_fin.cjk));
        n_word.alnum_total    = ute_pkg::f_sat_out(ute_pkg::EST_BITS'(i_fin.alnum));
        n_word.space_total    = ute_pkg::f_sat_out(ute_pkg::EST_BITS'(i_fin.space));
        n_word.symbol_total   = ute_pkg::f_sat_out(ute_pkg::EST_BITS'(i_fin.symbol));
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (fin_take) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (fin_take) begin
            r_word <= n_word;
        end
    end

    assign o_fin_take = fin_take;
    assign o_valid    = r_valid;
    assign o_word     = r_word;

endmodule

/* design/utf8_token_estimate_core.sv */
// utf8_token_estimate_core: top level of the utf-8 token estimator
// depends on ute_pkg, ute_decode, ute_tally and ute_result
//
// Usage: the input channel carries one byte of text per word, with last_byte set
// on the final byte. The output channel carries one word per text: the token
// estimate floor(cjk/2)+floor(2*alnum/5)+symbols and the four unit totals.
// Throughput: one input word per cycle while o_in_stall is low; the byte decode and counter
// update for each byte are combinational between the input register and the counters.
// Result path: the last byte and then its totals pass the input register, the totals
// stage and the output register before the result word shows on o_out_valid.
// Stall: non-final bytes keep flowing while a result waits on i_out_stall; a last
// byte waits in the input register only while the totals stage and the output
// register are full and i_out_stall is high, and then o_in_stall rises.
// Reset: synchronous active low; clears the pending window, all counters and
// every valid flag, so the next byte starts a new text.
module utf8_token_estimate_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  ute_pkg::t_in_word  i_in_word,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output ute_pkg::t_out_word o_out_word,
    input  logic               i_out_stall
);

    logic              r_s1_vld;
    ute_pkg::t_in_word r_s1_word;
    logic              s1_take;
    logic              fin_vld;
    logic              fin_take;
    ute_pkg::t_totals  fin;
    ute_pkg::t_incr    incr;

    // a last byte needs room in the totals stage
    assign s1_take    = r_s1_vld && (!r_s1_word.last_byte || !fin_vld || fin_take);
    assign o_in_stall = r_s1_vld && !s1_take;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_s1_vld <= 1'b1;
        end else if (s1_take) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_s1_word <= i_in_word;
        end
    end

    ute_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (s1_take),
        .i_word  (r_s1_word),
        .o_incr  (incr)
    );

    ute_tally u_tally (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (s1_take),
        .i_last     (r_s1_word.last_byte),
        .i_incr     (incr),
        .i_fin_take (fin_take),
        .o_fin_vld  (fin_vld),
        .o_fin      (fin)
    );

    ute_result u_result (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fin_vld  (fin_vld),
        .i_fin      (fin),
        .i_stall    (i_out_stall),
        .o_fin_take (fin_take),
        .o_valid    (o_out_valid),
        .o_word     (o_out_word)
    );

endmodule

/* design/ute_checker.sv */
// ute_checker: port-level assertions for utf8_token_estimate_core, bound to the top
// uses ute_pkg types
module ute_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input ute_pkg::t_in_word  i_in_word,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input ute_pkg::t_out_word o_out_word,
    input logic               i_out_stall
);

    // a stalled input word holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_word))
        else $error("stalled input word changed or dropped");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result word changed or dropped");

    // reset leaves no result pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // the estimate includes every symbol
    a_est_sym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.token_estimate >= o_out_word.symbol_total)
        else $error("token estimate below symbol total");

    // the estimate includes half the cjk count
    a_est_cjk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.token_estimate >= (o_out_word.cjk_total >> 1))
        else $error("token estimate below half the cjk total");

endmodule

bind utf8_token_estimate_core ute_checker u_checker (.*);

/* tb/utf8_token_estimate_core_tb.sv */
// utf8_token_estimate_core_tb: self-checking bench for the utf-8 token estimator core
// depends on ute_pkg and utf8_token_estimate_core; tracks the byte window and unit counts
// on its own and compares every result word field by field
module utf8_token_estimate_core_tb;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int RANDOM_CLEAN   = 1350;
    localparam int RANDOM_TOTAL   = 1800;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    ute_pkg::t_in_word  i_in_word   = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    ute_pkg::t_out_word o_out_word;
    logic               i_out_stall = 1'b0;

    utf8_token_estimate_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predicted state: undecided bytes and unit counters of the current text
    logic [7:0]                     window_q [3];
    int unsigned                    window_len;
    logic [ute_pkg::COUNT_BITS-1:0] cjk_cnt;
    logic [ute_pkg::COUNT_BITS-1:0] alnum_cnt;
    logic [ute_pkg::COUNT_BITS-1:0] space_cnt;
    logic [ute_pkg::COUNT_BITS-1:0] symbol_cnt;

    ute_pkg::t_out_word expected_totals_q [$];
    logic [7:0]  text_buf [$];
    int unsigned mismatch_count = 0;
    int unsigned bytes_sent;
    int unsigned texts_sent;
    int unsigned results_seen = 0;
    longint unsigned cjk_seen = 0;
    longint unsigned symbol_seen = 0;
    int unsigned burst_left;
    int unsigned idle_cycles = 0;

    function automatic logic [ute_pkg::COUNT_BITS-1:0] sat_bump(
        input logic [ute_pkg::COUNT_BITS-1:0] c
    );
        return (c == ute_pkg::COUNT_MAX) ? c : c + 1'b1;
    endfunction

    // continuation bytes a lead asks for, zero for anything that is not a lead
    function automatic int unsigned lead_len(input logic [7:0] b);
        casez (b)
            8'b110?????: return 1;
            8'b1110????: return 2;
            8'b11110???: return 3;
            default:     return 0;
        endcase
    endfunction

    task automatic count_ascii(input logic [7:0] b);
        if ((b >= ute_pkg::ASCII_0 && b <= ute_pkg::ASCII_9) ||
            (b >= ute_pkg::ASCII_UP_A && b <= ute_pkg::ASCII_UP_Z) ||
            (b >= ute_pkg::ASCII_LO_A && b <= ute_pkg::ASCII_LO_Z)) begin
            alnum_cnt = sat_bump(alnum_cnt);
        end else if (b == ute_pkg::ASCII_SPACE) begin
            space_cnt = sat_bump(space_cnt);
        end else begin
            symbol_cnt = sat_bump(symbol_cnt);
        end
    endtask

    // decide every unit the new byte completes; queue the totals on the last byte
    task automatic tally_byte(input logic [7:0] b, input logic last);
        logic [7:0]  w [4];
        int unsigned cnt, n, avail, lim, used, i;
        bit          bad, hold;
        logic [15:0] cp;
        logic [ute_pkg::COUNT_BITS+2:0] est;
        ute_pkg::t_out_word res;
        for (i = 0; i < window_len; i++) w[i] = window_q[i];
        w[window_len] = b;
        cnt  = window_len + 1;
        hold = 1'b0;
        while (cnt > 0 && !hold) begin
            used = 1;
            n    = lead_len(w[0]);
            if (w[0] < ute_pkg::ASCII_LIMIT) begin
                count_ascii(w[0]);
            end else if (n == 0) begin
                symbol_cnt = sat_bump(symbol_cnt);
            end else begin
                avail = cnt - 1;
                lim   = (avail < n) ? avail : n;
                bad   = 1'b0;
                for (i = 1; i <= lim; i++) begin
                    if (w[i][7:6] != 2'b10) bad = 1'b1;
                end
                if (bad) begin
                    // broken sequence: the lead alone is a symbol, rescan after it
                    symbol_cnt = sat_bump(symbol_cnt);
                end else if (avail >= n) begin
                    cp = {w[0][3:0], w[1][5:0], w[2][5:0]};
                    if (n == 2 && cp >= ute_pkg::CJK_LO && cp <= ute_pkg::CJK_HI) begin
                        cjk_cnt = sat_bump(cjk_cnt);
                    end else begin
                        symbol_cnt = sat_bump(symbol_cnt);
                    end
                    used = n + 1;
                end else if (last) begin
                    // truncated lead at the end of the text
                    symbol_cnt = sat_bump(symbol_cnt);
                end else begin
                    hold = 1'b1;
                end
            end
            if (!hold) begin
                for (i = 0; i + used < cnt; i++) w[i] = w[i + used];
                cnt -= used;
            end
        end
        for (i = 0; i < 3; i++) window_q[i] = (i < cnt) ? w[i] : 8'h00;
        window_len = cnt;

        if (last) begin
            est = (ute_pkg::COUNT_BITS+3)'(cjk_cnt >> 1)
                + ((ute_pkg::COUNT_BITS+3)'(alnum_cnt) * 2) / 5
                + (ute_pkg::COUNT_BITS+3)'(symbol_cnt);
            res.token_estimate = (est > (ute_pkg::COUNT_BITS+3)'(ute_pkg::OUT_MAX))
                               ? ute_pkg::OUT_MAX : ute_pkg::OUT_BITS'(est);
            res.cjk_total      = cjk_cnt;
            res.alnum_total    = alnum_cnt;
            res.space_total    = space_cnt;
            res.symbol_total   = symbol_cnt;
            expected_totals_q  = {expected_totals_q, res};
            cjk_cnt    = '0;
            alnum_cnt  = '0;
            space_cnt  = '0;
            symbol_cnt = '0;
            window_len = 0;
            for (i = 0; i < 3; i++) window_q[i] = 8'h00;
        end
    endtask

    // send one byte word; idle gaps fall between bursts of random length
    task automatic send_word(input logic [7:0] b, input logic last);
        ute_pkg::t_in_word w;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 12);
        end
        burst_left--;
        w.text_byte = b;
        w.last_byte = last;
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        tally_byte(b, last);
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        bytes_sent++;
        if (last) texts_sent++;
    endtask

    // send the buffered text, last flag on its final byte
    task automatic send_text();
        int unsigned i;
        for (i = 0; i < text_buf.size(); i++) begin
            send_word(text_buf[i], i == text_buf.size() - 1);
        end
        text_buf.delete();
    endtask

    // add one byte at the end of the text buffer
    task automatic add_text_byte(input logic [7:0] b);
        text_buf = {text_buf, b};
    endtask

    // utf-8 encode a code point into the text buffer with the given byte count
    task automatic append_code(input int unsigned cp, input int unsigned len);
        case (len)
            1: add_text_byte(8'(cp));
            2: begin
                add_text_byte(8'hC0 | 8'(cp >> 6));
                add_text_byte(8'h80 | 8'(cp & 32'h3F));
            end
            3: begin
                add_text_byte(8'hE0 | 8'(cp >> 12));
                add_text_byte(8'h80 | 8'((cp >> 6) & 32'h3F));
                add_text_byte(8'h80 | 8'(cp & 32'h3F));
            end
            default: begin
                add_text_byte(8'hF0 | 8'((cp >> 18) & 32'h07));
                add_text_byte(8'h80 | 8'((cp >> 12) & 32'h3F));
                add_text_byte(8'h80 | 8'((cp >> 6) & 32'h3F));
                add_text_byte(8'h80 | 8'(cp & 32'h3F));
            end
        endcase
    endtask

    // one well-formed unit of random content
    task automatic append_clean_unit();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            append_code($urandom_range(0, 127), 1);
        end else if (r < 35) begin
            case ($urandom_range(0, 2))
                0:       append_code(ute_pkg::ASCII_0 + $urandom_range(0, 9), 1);
                1:       append_code(ute_pkg::ASCII_UP_A + $urandom_range(0, 25), 1);
                default: append_code(ute_pkg::ASCII_LO_A + $urandom_range(0, 25), 1);
            endcase
        end else if (r < 42) begin
            append_code(ute_pkg::ASCII_SPACE, 1);
        end else if (r < 62) begin
            append_code($urandom_range(ute_pkg::CJK_LO, ute_pkg::CJK_HI), 3);
        end else if (r < 72) begin
            case ($urandom_range(0, 2))
                0:       append_code(ute_pkg::CJK_LO - 1, 3);
                1:       append_code(ute_pkg::CJK_HI + 1, 3);
                default: append_code($urandom_range(16'h0000, 16'hFFFF), 3);
            endcase
        end else if (r < 86) begin
            append_code($urandom_range(0, 16'h07FF), 2);
        end else begin
            append_code($urandom_range(0, 21'h1FFFFF), 4);
        end
    endtask

    // one unit of noise: stray bytes, broken or truncated sequences
    task automatic append_noise_unit();
        int unsigned k;
        case ($urandom_range(0, 3))
            0: add_text_byte(8'($urandom_range(0, 255)));
            1: add_text_byte(8'h80 | 8'($urandom_range(0, 63)));
            2: begin
                // lead, up to two continuations, then a byte that is not a continuation
                add_text_byte(8'hC0 | 8'($urandom_range(0, 55)));
                for (k = $urandom_range(0, 2); k > 0; k--) begin
                    add_text_byte(8'h80 | 8'($urandom_range(0, 63)));
                end
                add_text_byte(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 127))
                                                          : 8'hC0 | 8'($urandom_range(0, 63)));
            end
            default: begin
                // lead with too few continuation bytes
                add_text_byte(8'hE0 | 8'($urandom_range(0, 23)));
                for (k = $urandom_range(0, 1); k > 0; k--) begin
                    add_text_byte(8'h80 | 8'($urandom_range(0, 63)));
                end
            end
        endcase
    endtask

    function automatic int unsigned pick_text_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 40);
    endfunction

    // directed: every ascii class and both ends of the ascii range
    task automatic test_ascii_classes();
        text_buf = '{8'h00, ute_pkg::ASCII_9, ute_pkg::ASCII_UP_A, ute_pkg::ASCII_LO_Z,
                     ute_pkg::ASCII_SPACE, 8'h7F};
        send_text();
    endtask

    // directed: cjk range edges and the other valid multi-byte lengths
    task automatic test_multibyte_units();
        append_code(ute_pkg::CJK_LO, 3);
        append_code(ute_pkg::CJK_HI + 1, 3);
        append_code(32'h00E9, 2);
        append_code(32'h1F600, 4);
        send_text();
        append_code(ute_pkg::CJK_HI, 3);
        send_text();
    endtask

    // directed: bad leads, early bad continuation, truncation at the end
    task automatic test_malformed_sequences();
        text_buf = '{8'h80, 8'hFF, 8'hE4, ute_pkg::ASCII_UP_A, 8'hE4, 8'hB8};
        send_text();
        text_buf = '{8'hF0};
        send_text();
    endtask

    // random: well-formed texts with random content
    task automatic test_random_clean_texts();
        int unsigned len;
        while (bytes_sent < RANDOM_CLEAN) begin
            len = pick_text_len();
            while (text_buf.size() < len) append_clean_unit();
            send_text();
        end
    endtask

    // random: texts mixing valid units with noise and broken sequences
    task automatic test_random_noisy_texts();
        int unsigned len;
        while (bytes_sent < RANDOM_TOTAL) begin
            len = pick_text_len();
            while (text_buf.size() < len) begin
                if ($urandom_range(0, 1) == 0) append_noise_unit();
                else append_clean_unit();
            end
            send_text();
        end
    endtask

    // receiver stall pattern: rotates between none, periodic, light and heavy
    logic [9:0] stall_phase = '0;
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1'b1;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            case (stall_phase[9:8])
                2'd0:    i_out_stall <= 1'b0;
                2'd1:    i_out_stall <= (stall_phase[2:0] < 3'd5);
                2'd2:    i_out_stall <= ($urandom_range(0, 1) == 0);
                default: i_out_stall <= ($urandom_range(0, 99) < 85);
            endcase
        end
    end

    task automatic check_field(input string fname, input logic [ute_pkg::OUT_BITS-1:0] want,
                               input logic [ute_pkg::OUT_BITS-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
            mismatch_count++;
        end
    endtask

    // result checker: each accepted word against the oldest prediction
    always @(posedge i_clk) begin
        ute_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            cjk_seen    += o_out_word.cjk_total;
            symbol_seen += o_out_word.symbol_total;
            if (expected_totals_q.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got %h",
                         $time, o_out_word);
                mismatch_count++;
            end else begin
                want = expected_totals_q.pop_front();
                check_field("token_estimate", want.token_estimate, o_out_word.token_estimate);
                check_field("cjk_total", want.cjk_total, o_out_word.cjk_total);
                check_field("alnum_total", want.alnum_total, o_out_word.alnum_total);
                check_field("space_total", want.space_total, o_out_word.space_total);
                check_field("symbol_total", want.symbol_total, o_out_word.symbol_total);
            end
        end
    end

    // watchdog: too long without any word moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
            $display("[utf8_token_estimate_core] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        window_len     = 0;
        window_q       = '{8'h00, 8'h00, 8'h00};
        cjk_cnt        = '0;
        alnum_cnt      = '0;
        space_cnt      = '0;
        symbol_cnt     = '0;
        bytes_sent     = 0;
        texts_sent     = 0;
        burst_left     = 0;

        // reset
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_ascii_classes();
        test_multibyte_units();
        test_malformed_sequences();
        test_random_clean_texts();
        test_random_noisy_texts();
        i_in_valid <= 1'b0;

        // drain outstanding results
        while (expected_totals_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d bytes in %0d texts, checked %0d result words", bytes_sent,
                 texts_sent, results_seen);
        $display("texts held %0d cjk units and %0d symbol units in all", cjk_seen,
                 symbol_seen);
        if (mismatch_count == 0) begin
            $display("[utf8_token_estimate_core] OK");
        end else begin
            $display("[utf8_token_estimate_core] ERROR");
        end
        $finish;
    end

endmodule
